// ===== design/assert_macros.svh =====
// assertion macros for the notification block rtl, included by the datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define NTFQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define NTFQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define NTFQ_ASSERT(label, clk, rst_n, prop, msg)
`define NTFQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/ntfq_pkg.sv =====
// types and constants for the notification word with wait queue
`timescale 1ns / 1ps

package ntfq_pkg;

    localparam int MAX_WAITERS_DEF = 16;
    localparam int WORD_W          = 32;
    localparam int TID_W           = 16;
    localparam int S_TDATA_W       = 48;
    localparam int S_TUSER_W       = 2;
    // fixed output fields: success, woken, delivered, full, pending, idle
    localparam int OUT_FIXED_W     = 1 + TID_W + WORD_W + 1 + WORD_W + 1;

    typedef enum logic [1:0] {
        OP_SIGNAL = 2'd0,
        OP_WAIT   = 2'd1,
        OP_POLL   = 2'd2,
        OP_CANCEL = 2'd3
    } op_t;

    typedef struct packed {
        logic accept;
        logic exec_commit;
        logic scan_step;
        logic cancel_commit;
    } cmd_t;

    typedef struct packed {
        logic op_cancel;
        logic scan_done;
        logic out_free;
    } sts_t;

endpackage

// ===== design/ntfq_ctrl.sv =====
// controller state machine for the notification block
`timescale 1ns / 1ps

module ntfq_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  ntfq_pkg::sts_t sts,
    output ntfq_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next        = state_reg;
        cmd               = '0;
        s_tready          = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = sts.op_cancel ? ST_SCAN : ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (sts.out_free) begin
                    cmd.exec_commit = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (!sts.scan_done) begin
                    cmd.scan_step = 1'b1;
                end else if (sts.out_free) begin
                    cmd.cancel_commit = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/ntfq_dp.sv =====
// datapath: pending word, waiter queue memory and result register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ntfq_dp #(
    parameter int MAX_WAITERS = ntfq_pkg::MAX_WAITERS_DEF,
    parameter int PTR_W       = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1,
    parameter int CNT_W       = $clog2(MAX_WAITERS + 1),
    parameter int M_TDATA_W   = ((ntfq_pkg::OUT_FIXED_W + CNT_W + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ntfq_pkg::cmd_t                  cmd,
    output ntfq_pkg::sts_t                  sts,
    input  logic [ntfq_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [ntfq_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [M_TDATA_W-1:0]            m_tdata
);

    localparam int WORD_W = ntfq_pkg::WORD_W;
    localparam int TID_W  = ntfq_pkg::TID_W;
    localparam int OUT_W  = ntfq_pkg::OUT_FIXED_W + CNT_W;

    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                  input logic [CNT_W-1:0] ofs);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(ofs);
        if (sum >= (CNT_W + 1)'(MAX_WAITERS)) begin
            sum = sum - (CNT_W + 1)'(MAX_WAITERS);
        end
        return PTR_W'(sum);
    endfunction

    logic [TID_W-1:0]  mem [MAX_WAITERS];
    logic [TID_W-1:0]  rdata_reg;

    ntfq_pkg::op_t     op_reg;
    logic [WORD_W-1:0] bits_reg;
    logic [TID_W-1:0]  tid_reg;

    logic [WORD_W-1:0] word_reg,     word_next;
    logic [PTR_W-1:0]  rd_ptr_reg,   rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg,   wr_ptr_next;
    logic [CNT_W-1:0]  total_reg,    total_next;
    logic              idle_reg,     idle_next;
    logic [CNT_W-1:0]  scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]  keep_cnt_reg, keep_cnt_next;

    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;

    logic              mem_we;
    logic [PTR_W-1:0]  mem_waddr;
    logic [TID_W-1:0]  mem_wdata;
    logic [PTR_W-1:0]  mem_raddr;

    logic              res_success;
    logic [TID_W-1:0]  res_woken;
    logic [WORD_W-1:0] res_delivered;
    logic              res_full;
    logic [WORD_W-1:0] word_or;

    assign sts.op_cancel = (ntfq_pkg::op_t'(s_tuser) == ntfq_pkg::OP_CANCEL);
    assign sts.scan_done = (scan_idx_reg == total_reg);
    assign sts.out_free  = !out_valid_reg || m_tready;

    assign word_or   = word_reg | bits_reg;
    assign mem_raddr = wrap_add(rd_ptr_reg, scan_idx_next);

    always_comb begin
        word_next     = word_reg;
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        total_next    = total_reg;
        idle_next     = idle_reg;
        scan_idx_next = scan_idx_reg;
        keep_cnt_next = keep_cnt_reg;
        mem_we        = 1'b0;
        mem_waddr     = wr_ptr_reg;
        mem_wdata     = tid_reg;
        res_success   = 1'b0;
        res_woken     = '0;
        res_delivered = '0;
        res_full      = 1'b0;

        if (cmd.accept) begin
            keep_cnt_next = '0;
        end

        if (cmd.exec_commit) begin
            case (op_reg)
                ntfq_pkg::OP_SIGNAL: begin
                    if (total_reg != '0) begin
                        res_success   = 1'b1;
                        res_woken     = rdata_reg;
                        res_delivered = word_or;
                        word_next     = '0;
                        rd_ptr_next   = wrap_add(rd_ptr_reg, CNT_W'(1));
                        total_next    = total_reg - CNT_W'(1);
                        if (total_reg == CNT_W'(1)) begin
                            idle_next = 1'b1;
                        end
                    end else begin
                        word_next = word_or;
                    end
                end
                ntfq_pkg::OP_WAIT: begin
                    if (word_reg != '0) begin
                        res_success   = 1'b1;
                        res_delivered = word_reg;
                        word_next     = '0;
                    end else begin
                        idle_next = 1'b0;
                        if (total_reg == CNT_W'(MAX_WAITERS)) begin
                            res_full = 1'b1;
                        end else begin
                            mem_we      = 1'b1;
                            wr_ptr_next = wrap_add(wr_ptr_reg, CNT_W'(1));
                            total_next  = total_reg + CNT_W'(1);
                        end
                    end
                end
                ntfq_pkg::OP_POLL: begin
                    if (word_reg != '0) begin
                        res_success   = 1'b1;
                        res_delivered = word_reg;
                        word_next     = '0;
                    end
                end
                default: begin
                end
            endcase
        end

        // survivors are packed behind the read pointer in queue order
        if (cmd.scan_step) begin
            scan_idx_next = scan_idx_reg + CNT_W'(1);
            if (rdata_reg != tid_reg) begin
                mem_we        = 1'b1;
                mem_waddr     = wrap_add(rd_ptr_reg, keep_cnt_reg);
                mem_wdata     = rdata_reg;
                keep_cnt_next = keep_cnt_reg + CNT_W'(1);
            end
        end

        if (cmd.cancel_commit) begin
            scan_idx_next = '0;
            keep_cnt_next = '0;
            total_next    = keep_cnt_reg;
            wr_ptr_next   = wrap_add(rd_ptr_reg, keep_cnt_reg);
            if (keep_cnt_reg == '0) begin
                idle_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg   <= ntfq_pkg::op_t'(s_tuser);
            bits_reg <= s_tdata[WORD_W-1:0];
            tid_reg  <= s_tdata[WORD_W +: TID_W];
        end
        if (cmd.exec_commit || cmd.cancel_commit) begin
            out_data_reg <= {idle_next, total_next, word_next, res_full,
                             res_delivered, res_woken, res_success};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg      <= '0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            total_reg     <= '0;
            idle_reg      <= 1'b1;
            scan_idx_reg  <= '0;
            keep_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            word_reg     <= word_next;
            rd_ptr_reg   <= rd_ptr_next;
            wr_ptr_reg   <= wr_ptr_next;
            total_reg    <= total_next;
            idle_reg     <= idle_next;
            scan_idx_reg <= scan_idx_next;
            keep_cnt_reg <= keep_cnt_next;
            if (cmd.exec_commit || cmd.cancel_commit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_data_reg);

    `NTFQ_ASSERT(a_total_bound, aclk, aresetn, total_reg <= CNT_W'(MAX_WAITERS), "waiter count above depth")
    `NTFQ_ASSERT(a_keep_bound, aclk, aresetn, keep_cnt_reg <= scan_idx_reg, "survivors exceed scanned entries")
    `NTFQ_ASSERT_IMPL(a_commit_free, aclk, aresetn, cmd.exec_commit || cmd.cancel_commit, sts.out_free, "result loaded over a pending item")
    `NTFQ_ASSERT(a_cmd_onehot, aclk, aresetn, $onehot0({cmd.accept, cmd.exec_commit, cmd.scan_step, cmd.cancel_commit}), "conflicting commands")
    `NTFQ_ASSERT_IMPL(a_scan_range, aclk, aresetn, cmd.scan_step, scan_idx_reg < total_reg, "scan past queue end")

endmodule

// ===== design/notification_word_with_wait_queue.sv =====
// Notification word with wait queue: signal, wait, poll and cancel on one word.
// Signal, wait and poll: after accept the result is registered onto m_tvalid once the
// output slot is free. Cancel scans the N queued waiters, one waiter memory read per cycle,
// then loads its result; s_tready is high in idle only, after the last result is loaded.
// Reset clears the word, pointers and count and sets idle; queue memory is not cleared.
`timescale 1ns / 1ps

module notification_word_with_wait_queue #(
    parameter int MAX_WAITERS = ntfq_pkg::MAX_WAITERS_DEF,
    parameter int M_TDATA_W   =
        ((ntfq_pkg::OUT_FIXED_W + $clog2(MAX_WAITERS + 1) + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // signal_bits, thread_ident
    input  logic [ntfq_pkg::S_TDATA_W-1:0] s_tdata,
    // op
    input  logic [ntfq_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // success, woken_thread, delivered_word, queue_full, pending_word, waiter_count, idle
    output logic [M_TDATA_W-1:0]           m_tdata
);

    ntfq_pkg::cmd_t cmd;
    ntfq_pkg::sts_t sts;

    ntfq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ntfq_dp #(
        .MAX_WAITERS (MAX_WAITERS),
        .M_TDATA_W   (M_TDATA_W)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
